### design/bellman_ford_shortest_paths_defines.svh
// Assertion macros shared by the shortest-path checker.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bfsp_pkg.sv
// Shared types and constants of the shortest-path block.
package bfsp_pkg;

  localparam int VID_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int NV_W     = 7;
  localparam int EDGE_W   = 2 * VID_W + WEIGHT_W;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_SOURCE       = 1'b1;

  localparam logic [NV_W-1:0]  VERTEX_COUNT_RESET = 7'd64;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RUN,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [VID_W-1:0]           edge_from;
    logic [VID_W-1:0]           edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_EREAD,
    S_DREAD,
    S_CALC,
    S_UPD,
    S_NEGCYC,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

### design/bfsp_front.sv
// Command front end: decodes commands and queues them for the engine.
module bfsp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [bfsp_pkg::VID_W-1:0]    edge_from,
  input  logic [bfsp_pkg::VID_W-1:0]    edge_to,
  input  logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight,
  output bfsp_pkg::head_t           head,
  input  logic                      pop
);
  import bfsp_pkg::*;

  item_t      queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       push;
  logic       known;
  op_t        op;

  assign busy   = (count == 2'd2);
  assign accept = start && !busy;

  // Classify the command; drop unused codes
  always_comb begin
    known = 1'b1;
    op    = OP_LOAD;
    unique case (command)
      CMD_LOAD:  op = OP_LOAD;
      CMD_RUN:   op = OP_RUN;
      CMD_CLEAR: op = OP_CLEAR;
      default:   known = 1'b0;
    endcase
  end

  assign push = accept && known;

  // Hold queued beats
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: op, edge_from: edge_from, edge_to: edge_to,
                         edge_weight: edge_weight};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = queue[rd_ptr];

endmodule

### design/bfsp_engine.sv
// Back end: edge store, distance store and the relaxation sequencer.
module bfsp_engine #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfsp_pkg::NV_W-1:0]      vertex_count,
  input  logic [bfsp_pkg::VID_W-1:0]     source_vertex,
  input  bfsp_pkg::head_t                head,
  output logic                           pop,
  output logic                           result_valid,
  output logic [bfsp_pkg::VID_W-1:0]     vertex_index,
  output logic signed [bfsp_pkg::DIST_W-1:0] distance,
  output logic                           unreachable,
  output logic                           negative_cycle,
  output logic                           last
);
  import bfsp_pkg::*;

  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW  = $clog2(MAX_EDGES + 1);
  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NVW  = $clog2(MAX_VERTICES + 1);

  state_t state, state_next;

  // Stores
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reached;

  // Control registers
  logic [ETW-1:0] edge_total;
  logic [ETW-1:0] edge_idx;
  logic [NVW-1:0] nv;
  logic [NVW-1:0] rounds_left;
  logic [VID_W-1:0] src;
  logic           checking;
  logic [VW-1:0]  emit_idx;

  // Datapath registers
  logic [EDGE_W-1:0]        edata;
  logic signed [DIST_W-1:0] du, dv, cand;
  logic                     edge_ok, v_reached, emit_reached;
  logic [DIST_W-1:0]        emit_dist;

  // Decoded edge and helpers
  logic [VID_W-1:0]           e_from, e_to;
  logic signed [WEIGHT_W-1:0] e_weight;
  logic [VW-1:0]              u_a, v_a;
  logic                       u_in, v_in, src_in;
  logic [NVW-1:0]             nv_clamped;
  logic signed [DIST_W:0]     sum;
  logic signed [DIST_W-1:0]   sat_sum;
  logic                       improve, pass_end, emit_final;

  // Control outputs of the sequencer
  logic edge_we, dist_we, load_total, clear_total, start_run;

  assign e_from   = edata[EDGE_W-1 -: VID_W];
  assign e_to     = edata[EDGE_W-VID_W-1 -: VID_W];
  assign e_weight = edata[WEIGHT_W-1:0];
  assign u_a      = VW'(e_from);
  assign v_a      = VW'(e_to);
  assign u_in     = (int'(e_from) < int'(nv));
  assign v_in     = (int'(e_to) < int'(nv));
  assign src_in   = (int'(src) < int'(nv));

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    int vc;
    vc = int'(vertex_count);
    if (vc == 0) vc = 1;
    if (vc > MAX_VERTICES) vc = MAX_VERTICES;
    nv_clamped = NVW'(vc);
  end

  // Saturating add of distance and weight
  assign sum = {du[DIST_W-1], du} +
               {{(DIST_W+1-WEIGHT_W){e_weight[WEIGHT_W-1]}}, e_weight};
  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      sat_sum = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      sat_sum = sum[DIST_W-1:0];
    end
  end

  assign improve    = edge_ok && (!v_reached || (cand < dv));
  assign pass_end   = (edge_idx == edge_total);
  assign emit_final = (NVW'(emit_idx) == nv - NVW'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.valid && head.item.op == OP_RUN) state_next = S_INIT;
      end
      S_INIT:  state_next = S_EREAD;
      S_EREAD: begin
        if (!pass_end) state_next = S_DREAD;
        else if (checking) state_next = S_EMIT_RD;
      end
      S_DREAD: state_next = S_CALC;
      S_CALC:  state_next = S_UPD;
      S_UPD: begin
        if (improve && checking) state_next = S_NEGCYC;
        else state_next = S_EREAD;
      end
      S_NEGCYC:  state_next = S_IDLE;
      S_EMIT_RD: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        state_next = emit_final ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop         = 1'b0;
    edge_we     = 1'b0;
    load_total  = 1'b0;
    clear_total = 1'b0;
    start_run   = 1'b0;
    dist_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.item.op)
            OP_LOAD: begin
              edge_we    = (int'(edge_total) < MAX_EDGES);
              load_total = edge_we;
            end
            OP_CLEAR: clear_total = 1'b1;
            OP_RUN:   start_run   = 1'b1;
            default:  ;
          endcase
        end
      end
      S_UPD: dist_we = improve && !checking;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Edge store: write on load, registered read per edge
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[EW'(edge_total)] <= {head.item.edge_from, head.item.edge_to,
                                    head.item.edge_weight};
    end
    if (state == S_EREAD && !pass_end) edata <= edge_mem[EW'(edge_idx)];
  end

  // Distance store: one write port, three registered read ports
  always_ff @(posedge clk) begin
    if (state == S_INIT && src_in) begin
      dist_mem[VW'(src)] <= '0;
    end else if (dist_we) begin
      dist_mem[v_a] <= cand;
    end
    if (state == S_DREAD) begin
      du <= dist_mem[u_a];
      dv <= dist_mem[v_a];
    end
    if (state == S_EMIT_RD) emit_dist <= dist_mem[emit_idx];
  end

  // Reached bits: clear at run start, keeping only the source when in use
  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
    end else if (state == S_INIT) begin
      reached <= src_in ? (MAX_VERTICES'(1) << src) : '0;
    end else if (dist_we) begin
      reached[v_a] <= 1'b1;
    end
  end

  // Sequencer counters and datapath flags
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total  <= '0;
      edge_idx    <= '0;
      nv          <= NVW'(1);
      rounds_left <= '0;
      src         <= '0;
      checking    <= 1'b0;
      emit_idx    <= '0;
    end else begin
      if (load_total) edge_total <= edge_total + ETW'(1);
      if (clear_total) edge_total <= '0;
      if (start_run) begin
        nv  <= nv_clamped;
        src <= source_vertex;
      end
      unique case (state)
        S_INIT: begin
          rounds_left <= nv - NVW'(1);
          checking    <= (nv == NVW'(1));
          edge_idx    <= '0;
          emit_idx    <= '0;
        end
        S_EREAD: begin
          if (pass_end && !checking) begin
            edge_idx <= '0;
            if (rounds_left == NVW'(1)) checking <= 1'b1;
            else rounds_left <= rounds_left - NVW'(1);
          end
        end
        S_UPD:      edge_idx <= edge_idx + ETW'(1);
        S_EMIT_OUT: emit_idx <= emit_idx + VW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DREAD) begin
      edge_ok   <= u_in && v_in && reached[u_a];
      v_reached <= reached[v_a];
    end
    if (state == S_CALC) cand <= sat_sum;
    if (state == S_EMIT_RD) emit_reached <= reached[emit_idx];
  end

  // Drive one result beat per vertex, or the single cycle report
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      vertex_index   <= '0;
      distance       <= '0;
      unreachable    <= 1'b0;
      negative_cycle <= 1'b0;
      last           <= 1'b0;
    end else begin
      result_valid <= (state == S_NEGCYC) || (state == S_EMIT_OUT);
      if (state == S_NEGCYC) begin
        vertex_index   <= '0;
        distance       <= '0;
        unreachable    <= 1'b0;
        negative_cycle <= 1'b1;
        last           <= 1'b1;
      end else if (state == S_EMIT_OUT) begin
        vertex_index   <= VID_W'(emit_idx);
        distance       <= emit_reached ? emit_dist : DIST_MAX;
        unreachable    <= !emit_reached;
        negative_cycle <= 1'b0;
        last           <= emit_final;
      end
    end
  end

endmodule

### design/bellman_ford_shortest_paths.sv
// Top level of the single-source shortest-path engine.
// Commands enter on start/busy: a beat is taken at a rising edge with start
// high and busy low. Command 0 appends an edge, 2 empties the edge store,
// 1 runs the search; code 3 is dropped. A two-entry queue sits between the
// command front end and the engine, so busy rises only when it is full.
// In a run each edge passes through four steps (edge store read, distance
// store read, saturating add, compare and write), each sweep takes one more
// step to close it, and the edge list is swept vertex_count - 1 times plus
// one checking sweep. Results leave on result_valid, one beat per vertex,
// vertex 0 first; a negative cycle gives one beat only. The receiver cannot
// stall, so results are never held. Configuration writes arrive on
// cfg_valid/cfg_ready (always ready) and should land while the block is
// idle.
// Reset empties the queue and the edge store count, sets vertex_count to 64
// and source_vertex to 0. No clearing pass is needed after reset.
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command,
  input  logic [bfsp_pkg::VID_W-1:0]         edge_from,
  input  logic [bfsp_pkg::VID_W-1:0]         edge_to,
  input  logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [bfsp_pkg::NV_W-1:0]          cfg_data,
  output logic                               result_valid,
  output logic [bfsp_pkg::VID_W-1:0]         vertex_index,
  output logic signed [bfsp_pkg::DIST_W-1:0] distance,
  output logic                               unreachable,
  output logic                               negative_cycle,
  output logic                               last
);
  import bfsp_pkg::*;

  logic [NV_W-1:0]  vertex_count;
  logic [VID_W-1:0] source_vertex;
  head_t            head;
  logic             pop;

  assign cfg_ready = 1'b1;

  // Take configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RESET;
      source_vertex <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count  <= cfg_data;
        CFG_SOURCE:       source_vertex <= cfg_data[VID_W-1:0];
        default: ;
      endcase
    end
  end

  bfsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .edge_from   (edge_from),
    .edge_to     (edge_to),
    .edge_weight (edge_weight),
    .head        (head),
    .pop         (pop)
  );

  bfsp_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .vertex_count   (vertex_count),
    .source_vertex  (source_vertex),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .vertex_index   (vertex_index),
    .distance       (distance),
    .unreachable    (unreachable),
    .negative_cycle (negative_cycle),
    .last           (last)
  );

endmodule

### design/bfsp_checker.sv
// Port-level checks of the shortest-path block, bound to the top level.
`include "bellman_ford_shortest_paths_defines.svh"

module bfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic [5:0]  vertex_index,
  input logic [31:0] distance,
  input logic        unreachable,
  input logic        negative_cycle,
  input logic        last
);

  // A cycle report is always the only beat of its run
  `BFSP_ASSERT_NOW(a_negcyc_last, clk, rst, result_valid && negative_cycle, last, "cycle report without last")

  // A cycle report carries zero fields
  `BFSP_ASSERT_NOW(a_negcyc_fields, clk, rst, result_valid && negative_cycle, vertex_index == 6'd0 && distance == 32'd0 && !unreachable, "cycle report fields not zero")

  // Unreachable vertices report the saturated distance
  `BFSP_ASSERT_NOW(a_unreach_dist, clk, rst, result_valid && unreachable, distance == 32'h7FFF_FFFF && !negative_cycle, "unreachable distance wrong")

  // Result beats never come in adjacent cycles
  `BFSP_ASSERT_NEXT(a_beat_gap, clk, rst, result_valid, !result_valid, "back-to-back result beats")

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .vertex_index   (vertex_index),
  .distance       (distance),
  .unreachable    (unreachable),
  .negative_cycle (negative_cycle),
  .last           (last)
);
